// ===== rtl/core/utf8_to_utf16_transcoder_defines.svh =====
// assertion macros for the utf8 to utf16 transcoder checker
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define UTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define UTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/utt_pkg.sv =====
// types and constants shared by the utf8 to utf16 transcoder
`default_nettype none

package utt_pkg;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] MAX_POINT   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE   = 21'h010000;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [5:0]  HIGH_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_TAG     = 6'b110111;
    localparam int          MAX_UNITS   = 4;

    // input request: one utf8 byte
    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_string;
    } utf8_item_t;

    // output request: one utf16 code unit
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_end;
    } utf16_item_t;

    // all units caused by one byte, decoder to serializer
    typedef struct packed {
        logic                        push;
        logic [MAX_UNITS-1:0][15:0]  units;
        logic [2:0]                  count;
        logic                        eos;
    } burst_t;

endpackage

`default_nettype wire

// ===== rtl/core/utt_decoder.sv =====
// input register, sequence state and per-byte decode into a unit burst
`default_nettype none

module utt_decoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               utf8_valid,
    output logic                    utf8_stall,
    input  wire utt_pkg::utf8_item_t utf8_data,
    input  wire logic               ready,
    output utt_pkg::burst_t         burst
);

    logic                 full_reg;
    utt_pkg::utf8_item_t  item_reg;
    logic [1:0]           pending_reg,  pending_next;
    logic [2:0]           expect_reg,   expect_next;
    logic [20:0]          partial_reg,  partial_next;

    logic        accept;
    logic        advance;
    logic [7:0]  b;
    logic        eos;
    logic        cont;
    logic [2:0]  have;
    logic [20:0] cp;
    logic [20:0] lo;
    logic [20:0] supp;
    logic        bad;
    logic [2:0]  need;
    logic [20:0] bits;
    logic [2:0]  err_n;
    logic [1:0]  tail_n;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic [2:0]  slot;

    // input handshake
    assign accept     = utf8_valid && !utf8_stall;
    assign utf8_stall = full_reg && !ready;
    assign advance    = full_reg && ready;

    assign b    = item_reg.byte_in;
    assign eos  = item_reg.end_of_string;
    assign cont = (b[7:6] == 2'b10);
    assign have = {1'b0, pending_reg} + 3'd1;
    assign cp   = {partial_reg[14:0], b[5:0]};
    assign supp = cp - utt_pkg::SUPP_BASE;

    // lower bound per sequence length, and value check at the final byte
    always_comb
    begin
        priority if (expect_reg == 3'd2)
        begin
            lo = utt_pkg::MIN_TWO;
        end
        else if (expect_reg == 3'd3)
        begin
            lo = utt_pkg::MIN_THREE;
        end
        else
        begin
            lo = utt_pkg::SUPP_BASE;
        end
        bad = (cp < lo) || (cp > utt_pkg::MAX_POINT) ||
              ((cp >= utt_pkg::SURR_FIRST) && (cp <= utt_pkg::SURR_LAST));
    end

    // lead byte classification
    always_comb
    begin
        priority if (b[7:5] == 3'b110)
        begin
            need = 3'd2;
            bits = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            need = 3'd3;
            bits = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            need = 3'd4;
            bits = {18'd0, b[2:0]};
        end
        else
        begin
            need = 3'd0;
            bits = '0;
        end
    end

    // burst shape and next sequence state
    always_comb
    begin
        err_n        = 3'd0;
        tail_n       = 2'd0;
        tail0        = utt_pkg::REPLACEMENT;
        tail1        = utt_pkg::REPLACEMENT;
        pending_next = 2'd0;
        expect_next  = 3'd0;
        partial_next = '0;
        if ((pending_reg != 2'd0) && cont)
        begin
            if (have >= expect_reg)
            begin
                if (bad)
                begin
                    err_n = have;
                end
                else if (cp > 21'h00FFFF)
                begin
                    tail_n = 2'd2;
                    tail0  = {utt_pkg::HIGH_TAG, supp[19:10]};
                    tail1  = {utt_pkg::LOW_TAG, supp[9:0]};
                end
                else
                begin
                    tail_n = 2'd1;
                    tail0  = cp[15:0];
                end
            end
            else if (eos)
            begin
                err_n = have;
            end
            else
            begin
                pending_next = have[1:0];
                expect_next  = expect_reg;
                partial_next = cp;
            end
        end
        else
        begin
            // flush an interrupted sequence, then decode this byte afresh
            err_n = {1'b0, pending_reg};
            if (!b[7])
            begin
                tail_n = 2'd1;
                tail0  = {8'd0, b};
            end
            else if ((need == 3'd0) || eos)
            begin
                tail_n = 2'd1;
            end
            else
            begin
                pending_next = 2'd1;
                expect_next  = need;
                partial_next = bits;
            end
        end
    end

    // lay out the burst: replacements first, then the tail units
    always_comb
    begin
        for (int i = 0; i < utt_pkg::MAX_UNITS; i++)
        begin
            slot = 3'(i);
            if (slot < err_n)
            begin
                burst.units[i] = utt_pkg::REPLACEMENT;
            end
            else if (slot == err_n)
            begin
                burst.units[i] = tail0;
            end
            else
            begin
                burst.units[i] = tail1;
            end
        end
        burst.count = err_n + {1'b0, tail_n};
        burst.eos   = eos;
        burst.push  = advance && (burst.count != 3'd0);
    end

    // input register and sequence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg    <= 1'b0;
            pending_reg <= 2'd0;
            expect_reg  <= 3'd0;
            partial_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                full_reg <= 1'b1;
            end
            else if (advance)
            begin
                full_reg <= 1'b0;
            end
            if (advance)
            begin
                pending_reg <= pending_next;
                expect_reg  <= expect_next;
                partial_reg <= partial_next;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= utf8_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utt_serializer.sv =====
// result register that hands out a burst one code unit per request
`default_nettype none

module utt_serializer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire utt_pkg::burst_t     burst,
    output logic                     ready,
    output logic                     utf16_valid,
    input  wire logic                utf16_stall,
    output utt_pkg::utf16_item_t     utf16_data
);

    logic [2:0]                          count_reg;
    logic [utt_pkg::MAX_UNITS-1:0][15:0] units_reg;
    logic                                eos_reg;
    logic                                take;
    logic                                last;

    assign last  = (count_reg == 3'd1);
    assign take  = utf16_valid && !utf16_stall;
    assign ready = (count_reg == 3'd0) || (last && take);

    // output request from the head of the burst
    assign utf16_valid           = (count_reg != 3'd0);
    assign utf16_data.code_unit  = units_reg[0];
    assign utf16_data.run_last   = last;
    assign utf16_data.string_end = last && eos_reg;

    // burst count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else if (burst.push)
        begin
            count_reg <= burst.count;
        end
        else if (take)
        begin
            count_reg <= count_reg - 3'd1;
        end
    end

    // burst payload, shifted toward the head on each request taken
    always_ff @(posedge clk)
    begin
        if (burst.push)
        begin
            units_reg <= burst.units;
            eos_reg   <= burst.eos;
        end
        else if (take)
        begin
            for (int i = 0; i < utt_pkg::MAX_UNITS - 1; i++)
            begin
                units_reg[i] <= units_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// top level of the utf8 to utf16 transcoder
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------
//  utf8     | in  | utf8_valid/stall   | byte_in[7:0], end_of_string
//  utf16    | out | utf16_valid/stall  | code_unit[15:0], run_last, string_end
//
// one byte is taken per cycle while each byte yields at most one code unit and
// utf16_stall is low; a byte that yields k units (up to 4) holds the result
// register until all k are taken; a byte passes through the input register, then
// the result register, before its first unit is offered
// reset clears the sequence state and empties both registers; no sequence pending
// utf16_stall reaches utf8_stall via gates if input is full and one unit is left
`default_nettype none

module utf8_to_utf16_transcoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 utf8_valid,
    output logic                      utf8_stall,
    input  wire utt_pkg::utf8_item_t  utf8_data,
    output logic                      utf16_valid,
    input  wire logic                 utf16_stall,
    output utt_pkg::utf16_item_t      utf16_data
);

    utt_pkg::burst_t burst;
    logic            ready;

    // byte decode and sequence state
    utt_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf8_valid (utf8_valid),
        .utf8_stall (utf8_stall),
        .utf8_data  (utf8_data),
        .ready      (ready),
        .burst      (burst)
    );

    // code unit output
    utt_serializer u_serializer (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .ready       (ready),
        .utf16_valid (utf16_valid),
        .utf16_stall (utf16_stall),
        .utf16_data  (utf16_data)
    );

endmodule

`default_nettype wire

// ===== rtl/core/utt_checker.sv =====
// port-level checks for the utf8 to utf16 transcoder, bound to the top level
`default_nettype none
`include "utf8_to_utf16_transcoder_defines.svh"

module utt_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 utf8_valid,
    input  wire logic                 utf8_stall,
    input  wire utt_pkg::utf8_item_t  utf8_data,
    input  wire logic                 utf16_valid,
    input  wire logic                 utf16_stall,
    input  wire utt_pkg::utf16_item_t utf16_data
);

    // a stalled input request holds
    `UTT_ASSERT_NXT(a_in_hold, utf8_valid && utf8_stall, utf8_valid && $stable(utf8_data), "stalled input request changed")

    // a stalled output request holds
    `UTT_ASSERT_NXT(a_out_hold, utf16_valid && utf16_stall, utf16_valid && $stable(utf16_data), "stalled output request changed")

    // the end of a string closes the run of its byte
    `UTT_ASSERT_IMP(a_end_is_last, utf16_valid && utf16_data.string_end, utf16_data.run_last, "string_end without run_last")

    // a high surrogate is always followed by its low half from the same byte
    `UTT_ASSERT_IMP(a_high_not_last, utf16_valid && (utf16_data.code_unit[15:10] == utt_pkg::HIGH_TAG), !utf16_data.run_last, "high surrogate ends a run")

    // a low surrogate always ends the run of its byte
    `UTT_ASSERT_IMP(a_low_is_last, utf16_valid && (utf16_data.code_unit[15:10] == utt_pkg::LOW_TAG), utf16_data.run_last, "low surrogate does not end a run")

endmodule

bind utf8_to_utf16_transcoder utt_checker u_checker (.*);

`default_nettype wire
